// ===== sv/touch_gesture_qualifier_macros.svh =====
// ----------------------------------------------------------------------------
// touch_gesture_qualifier_macros
// assertion macros used by the touch gesture qualifier top module
// ----------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_QUALIFIER_MACROS_SVH
`define TOUCH_GESTURE_QUALIFIER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define TGQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define TGQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/tgq_pkg.sv =====
// ----------------------------------------------------------------------------
// tgq_pkg
// types, register codes and constants of the touch gesture qualifier
// ----------------------------------------------------------------------------
package tgq_pkg;

    localparam int WINDOW_LEN_DEF  = 4;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int SAMPLE_W  = 16;
    localparam int SUM_THR_W = 18;
    localparam int LEVEL_W   = 16;
    localparam int COUNT_W   = 8;
    localparam int EVENT_W   = 2;
    localparam int OSUM_W    = 18;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 18;
    localparam int OUT_DAT_W = 24;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [SUM_THR_W-1:0] SUM_THRESHOLD_RST   = 18'd50;
    localparam logic [COUNT_W-1:0]   SUM_RUN_NEEDED_RST  = 8'd1;
    localparam logic [LEVEL_W-1:0]   LOW_THRESHOLD_RST   = 16'd5;
    localparam logic [COUNT_W-1:0]   LOW_RUN_NEEDED_RST  = 8'd4;
    localparam logic [LEVEL_W-1:0]   HIGH_THRESHOLD_RST  = 16'd10;
    localparam logic [COUNT_W-1:0]   HIGH_RUN_LIMIT_RST  = 8'd10;
    localparam logic [COUNT_W-1:0]   STUCK_RUN_LIMIT_RST = 8'd25;
    localparam logic [COUNT_W-1:0]   VALID_WINDOW_RST    = 8'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SUM_THRESHOLD   = 4'd0,
        REG_SUM_RUN_NEEDED  = 4'd1,
        REG_LOW_THRESHOLD   = 4'd2,
        REG_LOW_RUN_NEEDED  = 4'd3,
        REG_HIGH_THRESHOLD  = 4'd4,
        REG_HIGH_RUN_LIMIT  = 4'd5,
        REG_STUCK_RUN_LIMIT = 4'd6,
        REG_VALID_WINDOW    = 4'd7
    } cfg_idx_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 2'd0,
        EV_TOUCH = 2'd1,
        EV_RECAL = 2'd2
    } event_t;

    typedef struct packed {
        logic [SUM_THR_W-1:0] sum_threshold;
        logic [COUNT_W-1:0]   sum_run_needed;
        logic [LEVEL_W-1:0]   low_threshold;
        logic [COUNT_W-1:0]   low_run_needed;
        logic [LEVEL_W-1:0]   high_threshold;
        logic [COUNT_W-1:0]   high_run_limit;
        logic [COUNT_W-1:0]   stuck_run_limit;
        logic [COUNT_W-1:0]   valid_window;
    } cfg_t;

    typedef struct packed {
        event_t              event_res;
        logic [OSUM_W-1:0]   window_sum;
    } result_t;

endpackage

// ===== sv/touch_gesture_qualifier.sv =====
// ----------------------------------------------------------------------------
// touch_gesture_qualifier
// qualifies touches and stuck-high conditions from a capacitive sample stream
// ----------------------------------------------------------------------------
// an accepted input beat passes the input register, then the output register, as its result beat
// throughput: one beat per cycle while m_tready is high, set by the single-pass update in tgq_core
// the input register takes a beat while a finished result is still held
// reset: asynchronous, clears window, counters, valid flags and config registers to defaults
module touch_gesture_qualifier #(
    parameter int WINDOW_LEN  = tgq_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = tgq_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tgq_pkg::SAMPLE_W-1:0]      s_tdata,   // sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tgq_pkg::OUT_DAT_W-1:0]     m_tdata,   // event_res, window_sum, zero pad
    input  logic                              cfg_wr_en,
    input  logic [tgq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tgq_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import tgq_pkg::*;

    `include "touch_gesture_qualifier_macros.svh"

    cfg_t                cfg;
    result_t             result;
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                out_valid_reg;
    result_t             out_reg;
    logic                advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    tgq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tgq_core #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .sample  (sample_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            sample_reg <= s_tdata;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DAT_W - EVENT_W - OSUM_W){1'b0}},
                       out_reg.window_sum, out_reg.event_res};

    // an event clears the window, so its beat always carries a zero sum
    `TGQ_ASSERT_NOW(a_event_zero_sum, out_valid_reg && (out_reg.event_res != EV_NONE),
                    out_reg.window_sum == '0)
    // input stage only refuses a beat while it holds one
    `TGQ_ASSERT_NOW(a_ready_when_empty, !s_tready, in_valid_reg)
    // a held input beat waits unchanged for the output register
    `TGQ_ASSERT_NEXT(a_in_hold, in_valid_reg && !advance,
                     in_valid_reg && $stable(sample_reg))
    // every advance produces a result beat
    `TGQ_ASSERT_NEXT(a_advance_out, advance, out_valid_reg)

endmodule

// ===== sv/tgq_cfg.sv =====
// ----------------------------------------------------------------------------
// tgq_cfg
// configuration register file, written by index, no read-back
// ----------------------------------------------------------------------------
module tgq_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [tgq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tgq_pkg::CFG_DAT_W-1:0]      cfg_data,
    output tgq_pkg::cfg_t                      cfg
);
    import tgq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_SUM_THRESHOLD:   cfg_next.sum_threshold   = cfg_data[SUM_THR_W-1:0];
                REG_SUM_RUN_NEEDED:  cfg_next.sum_run_needed  = cfg_data[COUNT_W-1:0];
                REG_LOW_THRESHOLD:   cfg_next.low_threshold   = cfg_data[LEVEL_W-1:0];
                REG_LOW_RUN_NEEDED:  cfg_next.low_run_needed  = cfg_data[COUNT_W-1:0];
                REG_HIGH_THRESHOLD:  cfg_next.high_threshold  = cfg_data[LEVEL_W-1:0];
                REG_HIGH_RUN_LIMIT:  cfg_next.high_run_limit  = cfg_data[COUNT_W-1:0];
                REG_STUCK_RUN_LIMIT: cfg_next.stuck_run_limit = cfg_data[COUNT_W-1:0];
                REG_VALID_WINDOW:    cfg_next.valid_window    = cfg_data[COUNT_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sum_threshold   <= SUM_THRESHOLD_RST;
            cfg_reg.sum_run_needed  <= SUM_RUN_NEEDED_RST;
            cfg_reg.low_threshold   <= LOW_THRESHOLD_RST;
            cfg_reg.low_run_needed  <= LOW_RUN_NEEDED_RST;
            cfg_reg.high_threshold  <= HIGH_THRESHOLD_RST;
            cfg_reg.high_run_limit  <= HIGH_RUN_LIMIT_RST;
            cfg_reg.stuck_run_limit <= STUCK_RUN_LIMIT_RST;
            cfg_reg.valid_window    <= VALID_WINDOW_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/tgq_core.sv =====
// ----------------------------------------------------------------------------
// tgq_core
// sample window, running sum, run counters and validity countdowns;
// one sample is folded in per advance
// ----------------------------------------------------------------------------
module tgq_core #(
    parameter int WINDOW_LEN  = tgq_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = tgq_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  advance,
    input  logic [tgq_pkg::SAMPLE_W-1:0]          sample,
    input  tgq_pkg::cfg_t                         cfg,
    output tgq_pkg::result_t                      result
);
    import tgq_pkg::*;

    localparam int SW    = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int SUM_W = SW + $clog2(WINDOW_LEN + 1);
    localparam int CMP_W = (SUM_W > SUM_THR_W) ? SUM_W : SUM_THR_W;
    localparam int LVL_W = (SW > LEVEL_W) ? SW : LEVEL_W;
    localparam int OUT_W = (SUM_W > OSUM_W) ? SUM_W : OSUM_W;

    logic [SW-1:0]      win_reg [WINDOW_LEN];
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [COUNT_W-1:0] sum_cnt_reg, sum_cnt_next;
    logic [COUNT_W-1:0] low_cnt_reg, low_cnt_next;
    logic [COUNT_W-1:0] high_cnt_reg, high_cnt_next;
    logic [COUNT_W-1:0] sum_left_reg, sum_left_next;
    logic [COUNT_W-1:0] low_left_reg, low_left_next;

    logic [SW-1:0]      s;
    logic [SUM_W-1:0]   sum_step;
    logic               sum_hit, low_hit, high_hit;
    logic [COUNT_W-1:0] sum_bump, low_bump, high_bump;
    logic [COUNT_W-1:0] sum_left_ld, low_left_ld;
    logic [COUNT_W-1:0] sum_cnt_step, low_cnt_step, high_cnt_step;
    event_t             ev;

    always_comb
    begin
        s        = sample[SW-1:0];
        sum_step = sum_reg - SUM_W'(win_reg[WINDOW_LEN-1]) + SUM_W'(s);
        sum_hit  = CMP_W'(sum_step) >= CMP_W'(cfg.sum_threshold);
        low_hit  = LVL_W'(s) >= LVL_W'(cfg.low_threshold);
        high_hit = LVL_W'(s) >= LVL_W'(cfg.high_threshold);

        sum_bump  = (sum_cnt_reg == COUNT_MAX) ? COUNT_MAX : sum_cnt_reg + 1'b1;
        low_bump  = (low_cnt_reg == COUNT_MAX) ? COUNT_MAX : low_cnt_reg + 1'b1;
        high_bump = (high_cnt_reg == COUNT_MAX) ? COUNT_MAX : high_cnt_reg + 1'b1;

        // sum feature
        sum_left_ld = sum_left_reg;
        if (!sum_hit)
        begin
            sum_cnt_step = '0;
        end
        else if (sum_bump >= cfg.sum_run_needed)
        begin
            sum_cnt_step = cfg.sum_run_needed;
            sum_left_ld  = cfg.valid_window;
        end
        else
        begin
            sum_cnt_step = sum_bump;
        end

        // low-run feature
        low_left_ld = low_left_reg;
        if (!low_hit)
        begin
            low_cnt_step = '0;
        end
        else if (low_bump >= cfg.low_run_needed)
        begin
            low_cnt_step = cfg.low_run_needed;
            low_left_ld  = cfg.valid_window;
        end
        else
        begin
            low_cnt_step = low_bump;
        end

        // high run, touch and recalibrate decision
        ev = EV_NONE;
        if (high_hit)
        begin
            high_cnt_step = high_bump;
            if (high_bump >= cfg.stuck_run_limit)
            begin
                ev = EV_RECAL;
            end
        end
        else
        begin
            high_cnt_step = '0;
            if ((high_cnt_reg <= cfg.high_run_limit) && (sum_left_ld != '0)
                && (low_left_ld != '0))
            begin
                ev = EV_TOUCH;
            end
        end

        if (ev != EV_NONE)
        begin
            sum_next      = '0;
            sum_cnt_next  = '0;
            low_cnt_next  = '0;
            high_cnt_next = '0;
            sum_left_next = '0;
            low_left_next = '0;
        end
        else
        begin
            sum_next      = sum_step;
            sum_cnt_next  = sum_cnt_step;
            low_cnt_next  = low_cnt_step;
            high_cnt_next = high_cnt_step;
            sum_left_next = (sum_left_ld != '0) ? sum_left_ld - 1'b1 : sum_left_ld;
            low_left_next = (low_left_ld != '0) ? low_left_ld - 1'b1 : low_left_ld;
        end

        result.event_res  = ev;
        result.window_sum = OSUM_W'(OUT_W'(sum_next));
    end

    // window kept as a shift line: oldest entry always at the last tap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                win_reg[i] <= '0;
            end
            sum_reg      <= '0;
            sum_cnt_reg  <= '0;
            low_cnt_reg  <= '0;
            high_cnt_reg <= '0;
            sum_left_reg <= '0;
            low_left_reg <= '0;
        end
        else if (advance)
        begin
            if (ev != EV_NONE)
            begin
                for (int i = 0; i < WINDOW_LEN; i++)
                begin
                    win_reg[i] <= '0;
                end
            end
            else
            begin
                win_reg[0] <= s;
                for (int i = 1; i < WINDOW_LEN; i++)
                begin
                    win_reg[i] <= win_reg[i-1];
                end
            end
            sum_reg      <= sum_next;
            sum_cnt_reg  <= sum_cnt_next;
            low_cnt_reg  <= low_cnt_next;
            high_cnt_reg <= high_cnt_next;
            sum_left_reg <= sum_left_next;
            low_left_reg <= low_left_next;
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the touch gesture qualifier: samples go in on the
// slave stream, a local model of the window sum, run counters and validity
// countdowns predicts every result beat, and the master stream is compared
// beat by beat under random stalls on both sides and several register sets
// ----------------------------------------------------------------------------
module tb_top;
    import tgq_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 40;
    localparam int WIN_LEN       = WINDOW_LEN_DEF;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [SAMPLE_W-1:0]  s_tdata;    // sample
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_DAT_W-1:0] m_tdata;    // event_res, window_sum, zero pad
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    touch_gesture_qualifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // model state
    cfg_t                 cur_cfg;
    logic [SAMPLE_W-1:0]  win [WIN_LEN];
    int                   slot;
    logic [OSUM_W-1:0]    run_sum;
    logic [COUNT_W-1:0]   sum_cnt;
    logic [COUNT_W-1:0]   low_cnt;
    logic [COUNT_W-1:0]   high_cnt;
    logic [COUNT_W-1:0]   sum_left;
    logic [COUNT_W-1:0]   low_left;

    result_t              pending_results [$];

    int src_idle_pct  = 20;
    int sink_idle_pct = 20;
    int fail_count    = 0;
    int n_samples     = 0;
    int n_results     = 0;
    int n_touch       = 0;
    int n_recal       = 0;
    int n_settings    = 0;
    int stall_cycles  = 0;

    result_t got_beat;
    result_t want_beat;

    function automatic cfg_t default_cfg();
        cfg_t c;
        c.sum_threshold   = SUM_THRESHOLD_RST;
        c.sum_run_needed  = SUM_RUN_NEEDED_RST;
        c.low_threshold   = LOW_THRESHOLD_RST;
        c.low_run_needed  = LOW_RUN_NEEDED_RST;
        c.high_threshold  = HIGH_THRESHOLD_RST;
        c.high_run_limit  = HIGH_RUN_LIMIT_RST;
        c.stuck_run_limit = STUCK_RUN_LIMIT_RST;
        c.valid_window    = VALID_WINDOW_RST;
        return c;
    endfunction

    function automatic void clear_gesture_state();
        for (int i = 0; i < WIN_LEN; i++)
            win[i] = '0;
        slot     = 0;
        run_sum  = '0;
        sum_cnt  = '0;
        low_cnt  = '0;
        high_cnt = '0;
        sum_left = '0;
        low_left = '0;
    endfunction

    function automatic logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
    endfunction

    // one sample through window, features and touch qualification
    function automatic result_t qualify_sample(logic [SAMPLE_W-1:0] s);
        result_t     r;
        event_t      ev;
        logic [19:0] acc;
        ev  = EV_NONE;
        acc = {2'b00, run_sum} - {4'h0, win[slot]} + {4'h0, s};
        run_sum   = acc[OSUM_W-1:0];
        win[slot] = s;
        slot      = (slot + 1) % WIN_LEN;

        if (run_sum >= cur_cfg.sum_threshold)
        begin
            sum_cnt = bump(sum_cnt);
            if (sum_cnt >= cur_cfg.sum_run_needed)
            begin
                sum_left = cur_cfg.valid_window;
                sum_cnt  = cur_cfg.sum_run_needed;
            end
        end
        else
            sum_cnt = '0;

        if (s >= cur_cfg.low_threshold)
        begin
            low_cnt = bump(low_cnt);
            if (low_cnt >= cur_cfg.low_run_needed)
            begin
                low_left = cur_cfg.valid_window;
                low_cnt  = cur_cfg.low_run_needed;
            end
        end
        else
            low_cnt = '0;

        if (s >= cur_cfg.high_threshold)
        begin
            high_cnt = bump(high_cnt);
            if (high_cnt >= cur_cfg.stuck_run_limit)
                ev = EV_RECAL;
        end
        else
        begin
            if (high_cnt <= cur_cfg.high_run_limit && sum_left != 0 && low_left != 0)
                ev = EV_TOUCH;
            high_cnt = '0;
        end

        if (sum_left != 0)
            sum_left--;
        if (low_left != 0)
            low_left--;

        if (ev != EV_NONE)
            clear_gesture_state();

        r.event_res  = ev;
        r.window_sum = run_sum;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // result beats
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_beat.event_res  = event_t'(m_tdata[EVENT_W-1:0]);
            got_beat.window_sum = m_tdata[EVENT_W +: OSUM_W];
            n_results++;
            if (got_beat.event_res == EV_TOUCH)
                n_touch++;
            if (got_beat.event_res == EV_RECAL)
                n_recal++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected beat event_res", got_beat.event_res, -1);
            else
            begin
                want_beat = pending_results.pop_front();
                if (got_beat.event_res !== want_beat.event_res)
                    report_mismatch("event_res", got_beat.event_res, want_beat.event_res);
                if (got_beat.window_sum !== want_beat.window_sum)
                    report_mismatch("window_sum", got_beat.window_sum, want_beat.window_sum);
            end
        end
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // watchdog on accepted beats
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] no beat accepted for %0d cycles", $realtime, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_sample(logic [SAMPLE_W-1:0] v);
        while (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(qualify_sample(v));
        n_samples++;
    endtask

    // wait until the block is idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic poke_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_SUM_THRESHOLD:   cur_cfg.sum_threshold   = val[SUM_THR_W-1:0];
            REG_SUM_RUN_NEEDED:  cur_cfg.sum_run_needed  = val[COUNT_W-1:0];
            REG_LOW_THRESHOLD:   cur_cfg.low_threshold   = val[LEVEL_W-1:0];
            REG_LOW_RUN_NEEDED:  cur_cfg.low_run_needed  = val[COUNT_W-1:0];
            REG_HIGH_THRESHOLD:  cur_cfg.high_threshold  = val[LEVEL_W-1:0];
            REG_HIGH_RUN_LIMIT:  cur_cfg.high_run_limit  = val[COUNT_W-1:0];
            REG_STUCK_RUN_LIMIT: cur_cfg.stuck_run_limit = val[COUNT_W-1:0];
            REG_VALID_WINDOW:    cur_cfg.valid_window    = val[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(cfg_t c);
        settle();
        poke_reg(REG_SUM_THRESHOLD,   CFG_DAT_W'(c.sum_threshold));
        poke_reg(REG_SUM_RUN_NEEDED,  CFG_DAT_W'(c.sum_run_needed));
        poke_reg(REG_LOW_THRESHOLD,   CFG_DAT_W'(c.low_threshold));
        poke_reg(REG_LOW_RUN_NEEDED,  CFG_DAT_W'(c.low_run_needed));
        poke_reg(REG_HIGH_THRESHOLD,  CFG_DAT_W'(c.high_threshold));
        poke_reg(REG_HIGH_RUN_LIMIT,  CFG_DAT_W'(c.high_run_limit));
        poke_reg(REG_STUCK_RUN_LIMIT, CFG_DAT_W'(c.stuck_run_limit));
        poke_reg(REG_VALID_WINDOW,    CFG_DAT_W'(c.valid_window));
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    function automatic cfg_t random_cfg();
        cfg_t c;
        c.low_threshold   = LEVEL_W'($urandom_range(1, 3000));
        c.high_threshold  = LEVEL_W'(c.low_threshold + $urandom_range(1, 5000));
        c.sum_threshold   = SUM_THR_W'($urandom_range(0, 4 * c.high_threshold));
        c.sum_run_needed  = COUNT_W'($urandom_range(0, 4));
        c.low_run_needed  = COUNT_W'($urandom_range(0, 6));
        c.high_run_limit  = COUNT_W'($urandom_range(0, 12));
        c.stuck_run_limit = COUNT_W'($urandom_range(1, 30));
        c.valid_window    = COUNT_W'($urandom_range(0, 10));
        return c;
    endfunction

    // a level below the high threshold (any level when it is zero), mostly at or above the low one
    function automatic logic [SAMPLE_W-1:0] quiet_sample();
        if (cur_cfg.high_threshold == 0)
            return SAMPLE_W'($urandom_range(0, 65535));
        if (cur_cfg.low_threshold < cur_cfg.high_threshold && $urandom_range(0, 3) != 0)
            return SAMPLE_W'($urandom_range(cur_cfg.high_threshold - 1, cur_cfg.low_threshold));
        return SAMPLE_W'($urandom_range(cur_cfg.high_threshold - 1, 0));
    endfunction

    function automatic logic [SAMPLE_W-1:0] loud_sample();
        return SAMPLE_W'($urandom_range(65535, cur_cfg.high_threshold));
    endfunction

    // lead-in, a high burst, then a release below the high threshold
    task automatic send_gesture();
        int lead;
        int burst;
        lead = $urandom_range(0, 6);
        if ($urandom_range(0, 7) == 0)
            burst = $urandom_range(1, cur_cfg.stuck_run_limit + 2);
        else
            burst = $urandom_range(1, cur_cfg.high_run_limit + 2);
        repeat (lead) send_sample(quiet_sample());
        repeat (burst) send_sample(loud_sample());
        send_sample(quiet_sample());
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 5))
            0:       send_sample('0);
            1:       send_sample('1);
            default: send_sample(SAMPLE_W'($urandom_range(0, 65535)));
        endcase
    endtask

    // reset values, a touch built from a lead-in and a short high burst
    task automatic test_reset_defaults();
        send_sample(16'd5);
        send_sample(16'd9);
        send_sample(16'd9);
        send_sample(16'd9);
        send_sample(16'd20);
        send_sample(16'd20);
        send_sample(16'd0);
    endtask

    // full-scale samples saturate the window before a short stuck limit trips
    task automatic test_full_scale_stuck();
        settle();
        poke_reg(REG_STUCK_RUN_LIMIT, 18'd5);
        cfg_wr_en <= 1'b0;
        repeat (5) send_sample('1);
        send_sample('0);
    endtask

    // zero run needs, zero stuck limit, zero validity, oversized values masked
    task automatic test_zero_settings();
        settle();
        poke_reg(REG_HIGH_THRESHOLD,  18'd100);
        poke_reg(REG_SUM_THRESHOLD,   18'd0);
        poke_reg(REG_LOW_THRESHOLD,   18'd0);
        poke_reg(REG_SUM_RUN_NEEDED,  18'd0);
        poke_reg(REG_LOW_RUN_NEEDED,  18'd0);
        poke_reg(REG_VALID_WINDOW,    18'd5);
        poke_reg(REG_HIGH_RUN_LIMIT,  18'h3FF00);
        poke_reg(REG_STUCK_RUN_LIMIT, 18'h3FF00);
        cfg_wr_en <= 1'b0;
        send_sample(16'd7);
        send_sample(16'd150);
        send_sample(16'd99);
        send_sample(16'd0);
        settle();
        poke_reg(REG_VALID_WINDOW, 18'd0);
        cfg_wr_en <= 1'b0;
        send_sample(16'd40);
        send_sample(16'd200);
    endtask

    // writes to indexes past the last register must change nothing
    task automatic test_unmapped_index();
        settle();
        for (int k = 1; k <= 8; k++)
            poke_reg(CFG_IDX_W'(REG_VALID_WINDOW) + CFG_IDX_W'(k),
                     CFG_DAT_W'($urandom_range(0, 262143)));
        cfg_wr_en <= 1'b0;
        repeat (4) send_noise();
    endtask

    task automatic test_random_phases();
        int   budget;
        int   start;
        cfg_t c;
        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0:       c = default_cfg();
                1:       c = '1;
                2:       c = '0;
                default: c = random_cfg();
            endcase
            apply_config(c);
            // all-ones limits make long bursts, so that phase gets a small budget
            budget = (p == 2) ? 20 : (p == 1) ? 30 : 105;
            // one phase streams with no gaps on either side
            src_idle_pct  = (p == 3) ? 0 : 20;
            sink_idle_pct = (p == 3) ? 0 : 20;
            start = n_samples;
            while (n_samples - start < budget)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_noise();
                else
                    send_gesture();
            end
        end
        src_idle_pct  = 20;
        sink_idle_pct = 20;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        cur_cfg = default_cfg();
        clear_gesture_state();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_full_scale_stuck();
        test_zero_settings();
        test_unmapped_index();
        test_random_phases();
        settle();

        $display("%0d samples sent, %0d result beats checked", n_samples, n_results);
        $display("%0d touches and %0d recalibrations seen across %0d register sets",
                 n_touch, n_recal, n_settings);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/tgq_pkg.sv
sv/tgq_cfg.sv
sv/tgq_core.sv
sv/touch_gesture_qualifier.sv
bench/tb_top.sv
